// ===== rtl/core/mgwa_pkg.sv =====
// Package for the median gated window average block.
// Holds the fixed field widths and shared constants; no dependencies.
package mgwa_pkg;
    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned FRAC_W   = 12;
    localparam int unsigned FRAC_SH  = 8;
    localparam int unsigned THR_W    = 16;
    localparam logic [FRAC_W-1:0] FRAC_RESET = 12'd256;
endpackage

// ===== rtl/core/median_gated_window_average.sv =====
// Channel | Dir | tdata bits (low first)
// s (in)  | in  | [11:0] sample, [15:12] zero
// m (out) | out | [11:0] filtered, [15:12] zero
// cfg     | in  | i_cfg_wdata [11:0] outlier_fraction, Q4.8
// The time an item takes grows with the number of samples in the window and is shorter
// when no sample lies in the band, set by the single read port of the window memory
// walked by the median rank search.
// One item is worked on at a time.
// Reset is synchronous and active low; there is no memory clearing pass.
// A result waits in the output register while the next item is taken.
// Top level of the median gated window average; uses mgwa_pkg, mgwa_mem, mgwa_div.
module median_gated_window_average
    import mgwa_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [11:0] sample
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [11:0] filtered
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = SAMPLE_W + CW;

    typedef enum logic [3:0] {
        S_IDLE, S_MM, S_THR, S_CAND, S_CANDW, S_RANK, S_CHK,
        S_MED, S_BAND, S_DIVST, S_DIV, S_DONE
    } t_state;

    t_state              r_state;
    logic [FRAC_W-1:0]   r_frac;
    logic [AW-1:0]       r_slot;
    logic [CW-1:0]       r_fill;
    logic [CW-1:0]       r_i;
    logic [CW-1:0]       r_j;
    logic                r_pend;
    logic [SAMPLE_W-1:0] r_lo, r_hi, r_cand, r_m1, r_m2, r_med, r_res;
    logic [THR_W-1:0]    r_thr;
    logic [CW-1:0]       r_less, r_leq, r_cnt;
    logic [SW-1:0]       r_sum;
    logic                r_out_vld;
    logic [SAMPLE_W-1:0] r_out;

    logic                w_acc, w_issue, w_sweep_done, w_div_start, w_div_done;
    logic [AW-1:0]       w_raddr;
    logic [SAMPLE_W-1:0] w_rdata;
    logic [SW-1:0]       w_quot;
    logic [CW-1:0]       w_k1, w_k2;
    logic [THR_W:0]      w_vt, w_mt;
    logic [2*SAMPLE_W-1:0] w_prod;

    assign w_acc   = i_s_tvalid && o_s_tready;
    assign w_issue = (r_state == S_MM || r_state == S_RANK || r_state == S_BAND)
                     && (r_j < r_fill);
    assign w_sweep_done = (r_j == r_fill) && !r_pend;
    assign w_raddr = (r_state == S_CAND) ? r_i[AW-1:0] : r_j[AW-1:0];
    assign w_k1 = (r_fill - 1'b1) >> 1;
    assign w_k2 = r_fill >> 1;
    assign w_vt = (THR_W+1)'(w_rdata) + (THR_W+1)'(r_thr);
    assign w_mt = (THR_W+1)'(r_med) + (THR_W+1)'(r_thr);
    assign w_prod = (r_hi - r_lo) * r_frac;
    assign w_div_start = (r_state == S_DIVST);

    mgwa_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_acc),
        .i_waddr(r_slot),
        .i_wdata(i_s_tdata[SAMPLE_W-1:0]),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    mgwa_div #(.NW(SW), .DW(CW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (r_sum),
        .i_den  (r_cnt),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_frac    <= FRAC_RESET;
            r_slot    <= '0;
            r_fill    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frac <= i_cfg_wdata;
            end
            if (o_m_tvalid && i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            r_pend <= w_issue;
            if (w_issue) begin
                r_j <= r_j + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_slot  <= (r_slot == AW'(DEPTH - 1)) ? '0 : r_slot + 1'b1;
                        if (r_fill != CW'(DEPTH)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_j     <= '0;
                        r_lo    <= '1;
                        r_hi    <= '0;
                        r_state <= S_MM;
                    end
                end
                S_MM: begin
                    if (r_pend) begin
                        if (w_rdata < r_lo) r_lo <= w_rdata;
                        if (w_rdata > r_hi) r_hi <= w_rdata;
                    end
                    if (w_sweep_done) r_state <= S_THR;
                end
                S_THR: begin
                    r_thr   <= w_prod[FRAC_SH +: THR_W];
                    r_i     <= '0;
                    r_state <= S_CAND;
                end
                S_CAND: begin
                    r_state <= S_CANDW;
                end
                S_CANDW: begin
                    r_cand  <= w_rdata;
                    r_j     <= '0;
                    r_less  <= '0;
                    r_leq   <= '0;
                    r_state <= S_RANK;
                end
                S_RANK: begin
                    if (r_pend) begin
                        if (w_rdata < r_cand)  r_less <= r_less + 1'b1;
                        if (w_rdata <= r_cand) r_leq  <= r_leq + 1'b1;
                    end
                    if (w_sweep_done) r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_less <= w_k1 && w_k1 < r_leq) r_m1 <= r_cand;
                    if (r_less <= w_k2 && w_k2 < r_leq) r_m2 <= r_cand;
                    r_i <= r_i + 1'b1;
                    r_state <= (r_i + 1'b1 == r_fill) ? S_MED : S_CAND;
                end
                S_MED: begin
                    r_med   <= SAMPLE_W'(({1'b0, r_m1} + {1'b0, r_m2}) >> 1);
                    r_j     <= '0;
                    r_sum   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_BAND;
                end
                S_BAND: begin
                    if (r_pend && w_vt >= (THR_W+1)'(r_med)
                        && (THR_W+1)'(w_rdata) <= w_mt) begin
                        r_sum <= r_sum + SW'(w_rdata);
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (w_sweep_done) begin
                        r_state <= S_DIVST;
                    end
                end
                S_DIVST: begin
                    if (r_cnt == '0) begin
                        r_res   <= r_med;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res   <= w_quot[SAMPLE_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_vld) begin
                        r_out_vld <= 1'b1;
                        r_out     <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'b0000, r_out};
endmodule

// ===== rtl/core/mgwa_mem.sv =====
// Window sample memory: one write port and one read port, registered read.
// Depends on mgwa_pkg.
module mgwa_mem
    import mgwa_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic [SAMPLE_W-1:0] i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output logic [SAMPLE_W-1:0] o_rdata
);
    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/mgwa_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on mgwa_pkg.
module mgwa_div
    import mgwa_pkg::*;
#(
    parameter int unsigned NW = 17,
    parameter int unsigned DW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int unsigned SCW = $clog2(NW + 1);

    logic [NW-1:0]  r_q;
    logic [DW:0]    r_rem;
    logic [DW-1:0]  r_den;
    logic [SCW-1:0] r_steps;
    logic           r_busy;
    logic           r_done;
    logic [DW:0]    w_shift;
    logic [DW+1:0]  w_trial;

    assign w_shift = {r_rem[DW-1:0], r_q[NW-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_q     <= i_num;
                r_rem   <= '0;
                r_den   <= i_den;
                r_steps <= SCW'(NW);
            end else if (r_busy) begin
                if (!w_trial[DW+1]) begin
                    r_rem <= w_trial[DW:0];
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_steps <= r_steps - 1'b1;
                if (r_steps == SCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== rtl/core/mgwa_checker.sv =====
// Port checker for median_gated_window_average, bound to the top level.
// Depends on mgwa_pkg only for the common import style.
module mgwa_checker
    import mgwa_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready && !$rose(o_m_tvalid))
        else $error("block took or finished an item right after accepting one");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("reset did not clear the handshake state");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[15:12] == 4'b0000)
        else $error("padding bits set");
endmodule

bind median_gated_window_average mgwa_checker u_mgwa_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata)
);

// ===== verif/median_gated_window_average_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for median_gated_window_average.
// Needs mgwa_pkg and the block's RTL. A clocked driver and monitor check each
// result against an in-bench median-gated window average predictor.
module median_gated_window_average_tb;
    import mgwa_pkg::*;

    localparam int unsigned WIN_DEPTH  = 16;
    localparam int unsigned SETTLE_CYC = 400;
    localparam int unsigned STALL_LIM  = 20000;
    localparam int unsigned LONG_HOLD  = 3000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [15:0]         i_s_tdata;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [15:0]         o_m_tdata;
    logic                i_cfg_we;
    logic [11:0]         i_cfg_wdata;

    logic [SAMPLE_W-1:0] pending_samples[$];
    logic [SAMPLE_W-1:0] expected_filtered[$];
    logic [SAMPLE_W-1:0] win_model[WIN_DEPTH];
    int unsigned         win_slot;
    int unsigned         win_fill;
    logic [FRAC_W-1:0]   band_fraction;
    int unsigned         mismatch_count;
    bit                  idle_enable;
    int unsigned         long_hold_reqs;
    int unsigned         long_hold_done;
    int unsigned         tx_gap;
    int unsigned         rx_gap;
    int unsigned         stall_cycles;

    median_gated_window_average #(.DEPTH(WIN_DEPTH)) dut (.*);

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [SAMPLE_W-1:0] gated_average(input logic [SAMPLE_W-1:0] smp);
        int unsigned sorted[WIN_DEPTH];
        int unsigned v;
        int unsigned j;
        int unsigned med;
        int unsigned lo;
        int unsigned hi;
        int unsigned thr;
        int unsigned sum;
        int unsigned cnt;
        longint      band_lo;
        longint      band_hi;
        win_model[win_slot] = smp;
        win_slot = (win_slot + 1 >= WIN_DEPTH) ? 0 : win_slot + 1;
        if (win_fill < WIN_DEPTH)
            win_fill++;
        lo = win_model[0];
        hi = win_model[0];
        for (int i = 0; i < win_fill; i++) begin
            v = win_model[i];
            if (v < lo)
                lo = v;
            if (v > hi)
                hi = v;
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        if (win_fill % 2 == 1)
            med = sorted[win_fill/2];
        else
            med = (sorted[win_fill/2-1] + sorted[win_fill/2]) / 2;
        thr = ((hi - lo) * band_fraction) >> FRAC_SH;
        band_lo = longint'(med) - longint'(thr);
        band_hi = longint'(med) + longint'(thr);
        sum = 0;
        cnt = 0;
        for (int i = 0; i < win_fill; i++) begin
            if (longint'(win_model[i]) >= band_lo && longint'(win_model[i]) <= band_hi) begin
                sum += win_model[i];
                cnt++;
            end
        end
        return (cnt == 0) ? med[SAMPLE_W-1:0] : SAMPLE_W'(sum / cnt);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        bit nv;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                expected_filtered.push_back(gated_average(i_s_tdata[SAMPLE_W-1:0]));
            if (!(i_s_tvalid && !o_s_tready)) begin
                nv = 1'b0;
                if (tx_gap > 0)
                    tx_gap--;
                else if (idle_enable && $urandom_range(0, 7) == 0)
                    tx_gap = $urandom_range(1, 18) - 1;
                else if (pending_samples.size() > 0) begin
                    nv = 1'b1;
                    i_s_tdata <= {4'b0, pending_samples.pop_front()};
                end
                i_s_tvalid <= nv;
            end
        end
    end

    always @(posedge i_clk) begin
        bit nr;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_filtered.size() == 0)
                    report_mismatch("unexpected result", o_m_tdata[SAMPLE_W-1:0], 0);
                else if (o_m_tdata[SAMPLE_W-1:0] !== expected_filtered[0])
                    report_mismatch("filtered", o_m_tdata[SAMPLE_W-1:0],
                                    expected_filtered.pop_front());
                else
                    void'(expected_filtered.pop_front());
            end
            nr = 1'b1;
            if (long_hold_done != long_hold_reqs) begin
                long_hold_done++;
                rx_gap = LONG_HOLD;
            end
            if (rx_gap > 0) begin
                rx_gap--;
                nr = 1'b0;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(1, 18) - 1;
                nr = 1'b0;
            end
            i_m_tready <= nr;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stall_cycles = 0;
        else if (++stall_cycles >= STALL_LIM) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Checked at the falling edge, where the driver's updates have settled.
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_samples.size() > 0 || expected_filtered.size() > 0 || i_s_tvalid)
            @(negedge i_clk);
    endtask

    task automatic write_fraction(input logic [FRAC_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        band_fraction = value;
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned base;
        int unsigned spread;
        base = $urandom_range(0, 4095);
        spread = $urandom_range(0, 300);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 7) begin
                int v;
                v = int'(base) + int'($urandom_range(0, 2*spread)) - int'(spread);
                pending_samples.push_back(v < 0 ? 12'd0 : (v > 4095 ? 12'd4095 : 12'(v)));
            end else
                pending_samples.push_back(12'($urandom()));
            if ($urandom_range(0, 63) == 0)
                base = $urandom_range(0, 4095);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_m_tready    = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        win_slot      = 0;
        win_fill      = 0;
        band_fraction = FRAC_RESET;
        mismatch_count = 0;
        idle_enable   = 1'b1;
        long_hold_reqs = 0;
        long_hold_done = 0;
        stall_cycles  = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (win_model[i])
            win_model[i] = '0;
        // Extremes with the default fraction, through the whole fill of the window.
        pending_samples = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd2048, 12'd1, 12'd4094,
                            12'd2047, 12'd0, 12'd4095, 12'd100, 12'd200, 12'd300,
                            12'd4000, 12'd5, 12'd2730, 12'd1365, 12'd4095};
        wait_drained();

        // A zero band with an even count leaves the median alone.
        write_fraction(12'd0);
        pending_samples = '{12'd10, 12'd21, 12'd3000, 12'd3001};
        wait_drained();
        write_fraction(12'd4095);
        pending_samples = '{12'd0, 12'd4095, 12'd2048};

        write_fraction(12'd1);
        queue_random(200);
        long_hold_reqs++;
        write_fraction(12'd64);
        queue_random(250);
        write_fraction(12'd0);
        queue_random(150);
        write_fraction(12'd4095);
        queue_random(150);
        for (int p = 0; p < 4; p++) begin
            write_fraction(12'($urandom()));
            queue_random(150);
        end
        write_fraction(12'($urandom_range(0, 512)));
        queue_random(100);
        long_hold_reqs++;
        queue_random(50);
        wait_drained();
        write_fraction(12'd128);
        idle_enable = 1'b0;
        queue_random(200);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== median_gated_window_average.f =====
rtl/core/mgwa_pkg.sv
rtl/core/mgwa_mem.sv
rtl/core/mgwa_div.sv
rtl/core/median_gated_window_average.sv
rtl/core/mgwa_checker.sv
verif/median_gated_window_average_tb.sv
